@@ rtl/core/chisq_pkg.sv @@
`default_nettype none

package chisq_pkg;

  localparam int VAL_W   = 32;  // rates, uncertainties, terms (Q16.16)
  localparam int ACC_W   = 48;  // spectrum and overall sums (Q32.16)
  localparam int FREE_W  = 20;  // degrees of freedom
  localparam int CNT_W   = 13;  // bin count field
  localparam int CLAMP_W = 17;  // clamped bin count, holds the largest bin limit

  // housekeeping and accumulate requests towards the accumulator bank
  typedef struct packed {
    logic               open;     // first bin accepted
    logic               restart;  // with open: clear freedom and total first
    logic [CLAMP_W-1:0] count;    // clamped bin count
    logic               add;      // add term to both sums
    logic [VAL_W-1:0]   term;
  } chisq_acc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } chisq_div_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/chisq_in_if.sv @@
`default_nettype none

interface chisq_in_if;
  import chisq_pkg::*;

  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  observed_rate;
  logic [VAL_W-1:0]  model_rate;
  logic [VAL_W-1:0]  observed_unc;
  logic [VAL_W-1:0]  model_unc;
  logic              first_bin;
  logic              restart;
  logic [CNT_W-1:0]  bin_count;
  logic              last_bin;

  modport source (
    output valid, observed_rate, model_rate, observed_unc, model_unc,
           first_bin, restart, bin_count, last_bin,
    input  ready
  );

  modport sink (
    input  valid, observed_rate, model_rate, observed_unc, model_unc,
           first_bin, restart, bin_count, last_bin,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/chisq_out_if.sv @@
`default_nettype none

interface chisq_out_if;
  import chisq_pkg::*;

  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  term_value;
  logic [ACC_W-1:0]  spectrum_sum;
  logic [ACC_W-1:0]  overall_total;
  logic              divide_fault;
  logic              sum_done;

  modport source (
    output valid, term_value, spectrum_sum, overall_total, divide_fault, sum_done,
    input  ready
  );

  modport sink (
    input  valid, term_value, spectrum_sum, overall_total, divide_fault, sum_done,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/chisq_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle; the high half of the
// dividend must be below the divisor so that the quotient fits
module chisq_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [chisq_pkg::VAL_W-1:0]  dividend_hi,
  input  wire logic [chisq_pkg::VAL_W-1:0]  dividend_lo,
  input  wire logic [chisq_pkg::VAL_W-1:0]  divisor,
  output logic      [chisq_pkg::VAL_W-1:0]  quotient,
  output chisq_pkg::chisq_div_stat_t        stat
);
  import chisq_pkg::*;

  localparam int STEP_W = $clog2(VAL_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VAL_W - 1);

  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  shreg;
  logic [VAL_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    trial_sub;
  logic              fits;

  assign trial     = {rem, shreg[VAL_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend_hi;
      shreg <= dividend_lo;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= fits ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
      shreg <= {shreg[VAL_W-2:0], fits};
    end
  end

  assign quotient  = shreg;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

@@ rtl/core/chisq_acc.sv @@
`default_nettype none

// degrees of freedom, spectrum sum and overall total, all saturating
module chisq_acc (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire chisq_pkg::chisq_acc_ctrl_t    ctrl,
  output logic      [chisq_pkg::FREE_W-1:0]  freedom,
  output logic      [chisq_pkg::ACC_W-1:0]   spectrum,
  output logic      [chisq_pkg::ACC_W-1:0]   total
);
  import chisq_pkg::*;

  logic [FREE_W-1:0] free_base;
  logic [FREE_W:0]   free_sum;
  logic [ACC_W:0]    spec_sum;
  logic [ACC_W:0]    tot_sum;

  assign free_base = ctrl.restart ? '0 : freedom;
  assign free_sum  = {1'b0, free_base} + (FREE_W + 1)'(ctrl.count);
  assign spec_sum  = {1'b0, spectrum} + (ACC_W + 1)'(ctrl.term);
  assign tot_sum   = {1'b0, total} + (ACC_W + 1)'(ctrl.term);

  always_ff @(posedge clk) begin
    if (rst) begin
      freedom  <= '0;
      spectrum <= '0;
      total    <= '0;
    end else if (ctrl.open) begin
      freedom  <= free_sum[FREE_W] ? '1 : free_sum[FREE_W-1:0];
      spectrum <= '0;
      if (ctrl.restart) begin
        total <= '0;
      end
    end else if (ctrl.add) begin
      spectrum <= spec_sum[ACC_W] ? '1 : spec_sum[ACC_W-1:0];
      total    <= tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/chi_square_accumulator.sv @@
// one bin at a time: a bin passes MUL and CHK, then DIV1 unless the term is zero,
// saturates or has a zero divisor, then RED and, for a reduced term, DIV2, then
// ACC and OUT; a zero term or zero divisor goes from CHK straight to ACC; the
// restoring divider serves both divisions in 32 bit-serial steps. The next bin
// is taken the cycle after its result is loaded; a waiting result only holds OUT
// rst (synchronous, active high) clears the mode, the freedom, both sums and handshake
`default_nettype none

module chi_square_accumulator #(
  parameter int MAX_BINS = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  chisq_in_if.sink    bin,
  chisq_out_if.source term
);
  import chisq_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // ready for a bin
  localparam logic [2:0] S_MUL  = 3'd1;  // square the difference
  localparam logic [2:0] S_CHK  = 3'd2;  // pick zero, fault, saturation or division
  localparam logic [2:0] S_DIV1 = 3'd3;  // square over uncertainty
  localparam logic [2:0] S_RED  = 3'd4;  // reduced mode decision
  localparam logic [2:0] S_DIV2 = 3'd5;  // term over degrees of freedom
  localparam logic [2:0] S_ACC  = 3'd6;  // add term to both sums
  localparam logic [2:0] S_OUT  = 3'd7;  // hand result to the output register

  localparam logic [CLAMP_W-1:0] BIN_LIMIT = CLAMP_W'(MAX_BINS);

  logic [2:0]         state;
  logic               stat_mode;

  // per-bin working registers
  logic [VAL_W-1:0]   diff;
  logic [VAL_W-1:0]   dvs;
  logic               nonzero;
  logic               last;
  logic [2*VAL_W-1:0] sq;
  logic [2*VAL_W-1:0] sq_next;
  logic [VAL_W-1:0]   term_r;
  logic               fault;

  // output register
  logic               out_valid;
  logic [VAL_W-1:0]   out_term;
  logic [ACC_W-1:0]   out_spec;
  logic [ACC_W-1:0]   out_total;
  logic               out_fault;
  logic               out_done;

  logic               accept;
  logic               out_load;
  logic [CLAMP_W-1:0] count_ext;
  logic [CLAMP_W-1:0] count_clamped;

  // divider hookup
  logic               div_start;
  logic [VAL_W-1:0]   div_hi;
  logic [VAL_W-1:0]   div_lo;
  logic [VAL_W-1:0]   div_dvs;
  logic [VAL_W-1:0]   quotient;
  chisq_div_stat_t    div_stat;

  // accumulator bank hookup
  chisq_acc_ctrl_t    acc_ctrl;
  logic [FREE_W-1:0]  freedom;
  logic [ACC_W-1:0]   spectrum;
  logic [ACC_W-1:0]   total;

  assign bin.ready = (state == S_IDLE);
  assign accept    = bin.valid && bin.ready;
  assign out_load  = (state == S_OUT) && (!out_valid || term.ready);

  // bin counts above the limit count as the limit
  assign count_ext     = CLAMP_W'(bin.bin_count);
  assign count_clamped = (count_ext > BIN_LIMIT) ? BIN_LIMIT : count_ext;

  // 32 x 32 product, registered before the divider picks it up
  assign sq_next = diff * diff;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_mode <= 1'b0;
    end else if (cfg_we) begin
      stat_mode <= cfg_wdata;
    end
  end

  // first-bin housekeeping happens on acceptance, so the reduced division sees
  // the updated degrees of freedom
  always_comb begin
    acc_ctrl.open    = accept && bin.first_bin;
    acc_ctrl.restart = bin.restart;
    acc_ctrl.count   = count_clamped;
    acc_ctrl.add     = (state == S_ACC);
    acc_ctrl.term    = term_r;
  end

  chisq_acc u_acc (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (acc_ctrl),
    .freedom  (freedom),
    .spectrum (spectrum),
    .total    (total)
  );

  // divider operands: the square in the first pass, the term in the reduced pass
  always_comb begin
    div_start = 1'b0;
    div_hi    = sq[2*VAL_W-1:VAL_W];
    div_lo    = sq[VAL_W-1:0];
    div_dvs   = dvs;
    unique case (state)
      S_CHK: begin
        div_start = nonzero && (dvs != '0) && (sq[2*VAL_W-1:VAL_W] < dvs);
      end
      S_RED: begin
        div_hi    = '0;
        div_lo    = term_r;
        div_dvs   = VAL_W'(freedom);
        div_start = stat_mode && (term_r != '0) && (freedom != '0);
      end
      default: begin
      end
    endcase
  end

  chisq_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_hi (div_hi),
    .dividend_lo (div_lo),
    .divisor     (div_dvs),
    .quotient    (quotient),
    .stat        (div_stat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (!nonzero || dvs == '0) begin
            state <= S_ACC;
          end else if (div_start) begin
            state <= S_DIV1;
          end else begin
            state <= S_RED;
          end
        end
        S_DIV1: begin
          if (div_stat.done) begin
            state <= S_RED;
          end
        end
        S_RED: begin
          state <= div_start ? S_DIV2 : S_ACC;
        end
        S_DIV2: begin
          if (div_stat.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-bin datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      diff    <= (bin.observed_rate >= bin.model_rate) ?
                 bin.observed_rate - bin.model_rate :
                 bin.model_rate - bin.observed_rate;
      dvs     <= (bin.observed_rate != '0) ? bin.observed_unc : bin.model_unc;
      nonzero <= (bin.observed_rate != '0) || (bin.model_rate != '0);
      last    <= bin.last_bin;
    end
    if (state == S_MUL) begin
      sq <= sq_next;
    end
    if (state == S_CHK) begin
      fault <= 1'b0;
      if (!nonzero) begin
        term_r <= '0;
      end else if (dvs == '0) begin
        // zero divisor: saturate and flag, no reduced pass
        term_r <= '1;
        fault  <= 1'b1;
      end else if (!div_start) begin
        // quotient would not fit in 32 bits
        term_r <= '1;
      end
    end
    if ((state == S_DIV1 || state == S_DIV2) && div_stat.done) begin
      term_r <= quotient;
    end
    if (state == S_RED && stat_mode && term_r != '0 && freedom == '0) begin
      // no degrees of freedom to divide by
      term_r <= '1;
      fault  <= 1'b1;
    end
  end

  // output register, decoupled from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (term.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_term  <= term_r;
      out_spec  <= spectrum;
      out_total <= total;
      out_fault <= fault;
      out_done  <= last;
    end
  end

  assign term.valid         = out_valid;
  assign term.term_value    = out_term;
  assign term.spectrum_sum  = out_spec;
  assign term.overall_total = out_total;
  assign term.divide_fault  = out_fault;
  assign term.sum_done      = out_done;

  // a flagged result always carries the saturated term
  a_fault_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fault |-> out_term == '1)
    else $error("divide fault without saturated term");

  // the divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // adding a term never lowers the spectrum sum
  a_sum_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |=> spectrum >= $past(spectrum))
    else $error("spectrum sum decreased on accumulate");

endmodule

`default_nettype wire
